// ===== rtl/sha256_byte_stream_hasher_unit_defines.svh =====
// Assertion macros shared by the hasher RTL.
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// check a property outside reset
`define SBH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check a property at every edge, reset included
`define SBH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SBH_ASSERT(lbl, prop, msg)
`define SBH_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/sbh_pkg.sv =====
`default_nettype none
package sbh_pkg;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  // one queued word between front and back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } sbh_entry_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sbh_if.sv =====
`default_nettype none
interface sbh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;
  modport source (output valid, data_byte, byte_present, message_end, input ready);
  modport sink (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sbh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== rtl/sbh_front.sv =====
`default_nettype none
`include "sha256_byte_stream_hasher_unit_defines.svh"
module sbh_front
  import sbh_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sbh_in_if.sink      byte_i,
  output sbh_entry_t  q_entry_o,
  output logic        q_valid_o,
  input  wire logic   q_ready_i
);

  sbh_entry_t ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign byte_i.ready = (cnt_q != 2'd2);
  // drop words that carry neither a byte nor an end marker
  assign push = byte_i.valid & byte_i.ready & (byte_i.byte_present | byte_i.message_end);
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o & q_ready_i;
  assign q_entry_o = ent_q[rd_q];

  // hold the queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= '{data_byte: byte_i.data_byte, byte_present: byte_i.byte_present,
                       message_end: byte_i.message_end};
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  `SBH_ASSERT(a_cnt_range, cnt_q <= 2'd2, "queue count out of range")
  `SBH_ASSERT(a_push_grows, (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1, "push lost")
  `SBH_ASSERT(a_drop_empty, (!push) |=> cnt_q <= $past(cnt_q), "dropped word queued")

endmodule
`default_nettype wire

// ===== rtl/sbh_core.sv =====
`default_nettype none
`include "sha256_byte_stream_hasher_unit_defines.svh"
module sbh_core
  import sbh_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire sbh_entry_t q_entry_i,
  input  wire logic       q_valid_i,
  output logic            q_ready_o,
  sbh_out_if.source       digest_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_COMP, S_FIN, S_PAD, S_LEN, S_OUT
  } state_e;

  state_e      state_q, ret_q;
  logic [31:0] hash_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [23:0] cur_q;
  logic [5:0]  fill_q, rnd_q;
  logic [63:0] cnt_q, bits_q;
  logic        first_q;
  logic [2:0]  len_q, idx_q;

  logic        ins_en, blk_full;
  logic [7:0]  ins_byte;
  logic [63:0] cnt_d;
  logic [31:0] t1, t2, w_new;
  logic        out_fire;

  // pick the byte to append to the block
  always_comb begin
    ins_en   = 1'b0;
    ins_byte = 8'h00;
    unique case (state_q)
      S_IDLE: begin
        ins_en   = q_valid_i & q_entry_i.byte_present;
        ins_byte = q_entry_i.data_byte;
      end
      S_PAD: begin
        ins_en   = first_q | (fill_q != LenOffset);
        ins_byte = first_q ? PadByte : 8'h00;
      end
      S_LEN: begin
        ins_en   = 1'b1;
        ins_byte = bits_q[{~len_q, 3'b000} +: 8];
      end
      default: ;
    endcase
  end

  assign blk_full  = ins_en & (fill_q == 6'd63);
  assign cnt_d     = cnt_q + 64'(q_entry_i.byte_present);
  assign q_ready_o = (state_q == S_IDLE);

  // one compression round and one schedule word
  assign t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + RoundK[rnd_q] + w_q[0];
  assign t2 = big_sig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign w_new = small_sig1(w_q[14]) + w_q[9] + small_sig0(w_q[1]) + w_q[0];

  assign digest_o.valid       = (state_q == S_OUT);
  assign digest_o.digest_word = hash_q[idx_q];
  assign digest_o.word_index  = idx_q;
  assign digest_o.last_word   = (idx_q == 3'd7);
  assign out_fire = digest_o.valid & digest_o.ready;

  // pack bytes into the schedule window, shift it during rounds
  always_ff @(posedge clk_i) begin
    if (ins_en) begin
      if (fill_q[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= {cur_q, ins_byte};
      end else begin
        cur_q <= {cur_q[15:0], ins_byte};
      end
    end else if (state_q == S_COMP) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
    end
    if (state_q == S_COMP) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end else if (blk_full) begin
      v_q <= hash_q;
    end
  end

  // sequence absorb, compress, pad, length and digest output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      hash_q  <= InitHash;
      cnt_q   <= 64'd0;
      bits_q  <= 64'd0;
      fill_q  <= 6'd0;
      rnd_q   <= 6'd0;
      first_q <= 1'b0;
      len_q   <= 3'd0;
      idx_q   <= 3'd0;
    end else begin
      if (ins_en) fill_q <= fill_q + 6'd1;
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            cnt_q   <= cnt_d;
            bits_q  <= {cnt_d[60:0], 3'b000};
            first_q <= 1'b1;
            if (blk_full) begin
              state_q <= S_COMP;
              ret_q   <= q_entry_i.message_end ? S_PAD : S_IDLE;
            end else if (q_entry_i.message_end) begin
              state_q <= S_PAD;
            end
          end
        end
        S_COMP: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= S_FIN;
        end
        S_FIN: begin
          for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
          state_q <= ret_q;
        end
        S_PAD: begin
          if (ins_en) begin
            first_q <= 1'b0;
            if (blk_full) begin
              state_q <= S_COMP;
              ret_q   <= S_PAD;
            end
          end else begin
            state_q <= S_LEN;
            len_q   <= 3'd0;
          end
        end
        S_LEN: begin
          len_q <= len_q + 3'd1;
          if (blk_full) begin
            state_q <= S_COMP;
            ret_q   <= S_OUT;
            idx_q   <= 3'd0;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              hash_q  <= InitHash;
              cnt_q   <= 64'd0;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `SBH_ASSERT(a_rnd_idle, (state_q != S_COMP) |-> rnd_q == 6'd0, "round count left running")
  `SBH_ASSERT(a_len_aligned, (state_q == S_LEN) |-> fill_q[5:3] == 3'd7, "length misplaced")
  `SBH_ASSERT(a_restart, (out_fire && idx_q == 3'd7) |=> cnt_q == 64'd0 && state_q == S_IDLE,
              "no restart after digest")

endmodule
`default_nettype wire

// ===== rtl/sha256_byte_stream_hasher_unit.sv =====
// SHA-256 byte stream hasher.
// byte_i takes one message byte per word (valid/ready). byte_present marks a
// real byte; message_end closes the message; a word with neither is dropped.
// digest_o gives eight 32-bit words per message, word_index 0 (most
// significant) first, last_word set on the eighth.
// The back end takes plain bytes in S_IDLE; the 64th byte of a block
// starts 64 rounds on the single round unit, then one hash update.
// At message end padding and length go in one byte per cycle, except while
// a full block compresses, with a state change (S_PAD to S_LEN) before the
// length, and one or two compressions follow before digest_o raises
// valid.
// A two-word queue parts the input from the back end, so input is still
// taken while the digest waits. A stalled digest_o holds the current word
// and the back end; the queue then fills and byte_i drops ready.
// Reset loads the initial hash values, clears the byte count and empties
// the queue; the block buffer needs no clearing.
`default_nettype none
module sha256_byte_stream_hasher_unit
  import sbh_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sbh_in_if.sink    byte_i,
  sbh_out_if.source digest_o
);

  sbh_entry_t q_entry;
  logic       q_valid, q_ready;

  sbh_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_i),
    .q_entry_o (q_entry),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready)
  );

  sbh_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_entry_i (q_entry),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .digest_o  (digest_o)
  );

endmodule
`default_nettype wire
